// ===== rtl/mnt_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the mesh neighbor table.
// No dependencies.
package mnt_pkg;

  localparam logic [2:0] OP_DISCOVER = 3'd0;
  localparam logic [2:0] OP_UPLINK   = 3'd1;
  localparam logic [2:0] OP_DOWNLINK = 3'd2;
  localparam logic [2:0] OP_CLOSE    = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;
  localparam logic [2:0] OP_BEST     = 3'd5;
  localparam logic [2:0] OP_HANDLE   = 3'd6;
  localparam logic [2:0] OP_PURGE    = 3'd7;

  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_NOTCONN  = 2'd1;
  localparam logic [1:0] ST_UPLINK   = 2'd2;
  localparam logic [1:0] ST_DOWNLINK = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BADTYPE = 2'd1;
  localparam logic [1:0] STS_NONE    = 2'd2;

  localparam logic [3:0] HANDLE_NONE = 4'd15;

  localparam logic CFG_TYPE_MASK = 1'b0;
  localparam logic CFG_TIMEOUT   = 1'b1;

  localparam logic [15:0] TYPE_MASK_RST = 16'hFFFE;
  localparam logic [31:0] TIMEOUT_RST   = 32'd10000;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [47:0]       peer_addr;
    logic [1:0]        peer_addr_kind;
    logic signed [7:0] signal_dbm;
    logic [3:0]        metric_kind;
    logic [31:0]       metric_value;
    logic              can_connect;
    logic [3:0]        link_handle;
    logic [1:0]        wanted_state;
    logic [31:0]       time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        slot_index;
    logic [47:0]       entry_addr;
    logic [1:0]        entry_addr_kind;
    logic signed [7:0] entry_signal;
    logic [3:0]        entry_metric_kind;
    logic [31:0]       entry_metric;
    logic [3:0]        entry_handle;
    logic [1:0]        entry_state;
  } out_item_t;

  // One table entry as held in memory (link state lives in flops).
  typedef struct packed {
    logic [47:0] addr;
    logic [1:0]  addr_kind;
    logic [7:0]  signal;
    logic [3:0]  metric_kind;
    logic [31:0] metric;
    logic [3:0]  handle;
    logic [31:0] last_seen;
  } rec_t;

  localparam rec_t REC_RESET = '{addr: 48'd0, addr_kind: 2'd0, signal: 8'd0,
                                 metric_kind: 4'd0, metric: 32'd0,
                                 handle: HANDLE_NONE, last_seen: 32'd0};

endpackage

// ===== rtl/mnt_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mesh_neighbor_table_unit.sv =====
`timescale 1ns / 1ps
// Mesh neighbor table: fixed peer table for discovery, connect, aging, purge, queries.
// Depends on mnt_pkg and mnt_ram.
//
//   channel  ports                          handshake
//   input    start, busy, in_item           taken when start && !busy
//   result   out_valid, out_item            one-cycle strobe, no backpressure
//   config   cfg_we, cfg_idx, cfg_wdata     written on cfg_we, no wait
//
// Each item scans the table through the entry memory, one read per cycle.
// Items that touch a slot then pass through S_DECIDE and S_WRITE before the result;
// the others give the result from S_DECIDE. The memory read port sets the scan length.
// Synchronous reset empties the table at once (per-entry written bits, no sweep).
// busy stays high from accept until the result strobe.
module mesh_neighbor_table_unit
  import mnt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = $bits(rec_t);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_WRITE} state_t;

  state_t            state_r;
  in_item_t          item_r;
  logic [15:0]       type_mask_r;
  logic [31:0]       timeout_r;
  logic [1:0]        link_r [TABLE_ENTRIES];
  logic [1:0]        link_nxt [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written_r, written_nxt;
  logic [CW-1:0]     iss_r;
  logic              rd_valid_r;
  logic [IW-1:0]     rd_idx_r;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic              ev_r, ev_nxt;
  logic [IW-1:0]     ev_idx_r, ev_idx_nxt;
  logic [31:0]       best_r, best_nxt;
  logic [IW-1:0]     slot_r;
  logic              is_new_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  rec_t              ram_wdata, ram_q, rec_q, rec_new;
  logic [1:0]        st_j, st_new;
  logic [IW-1:0]     rec_idx;
  logic [47:0]       key_rev;
  logic [31:0]       limit;
  logic              reject;
  logic              dec_found, dec_new;
  logic [IW-1:0]     dec_slot;
  logic              accept;

  mnt_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign key_rev = {item_r.peer_addr[7:0], item_r.peer_addr[15:8],
                    item_r.peer_addr[23:16], item_r.peer_addr[31:24],
                    item_r.peer_addr[39:32], item_r.peer_addr[47:40]};
  assign reject  = (item_r.opcode == OP_DISCOVER) &&
                   !type_mask_r[item_r.metric_kind];

  // Entry that has never been written reads as its reset contents.
  assign rec_idx = (state_r == S_WRITE) ? slot_r : rd_idx_r;
  assign rec_q   = written_r[rec_idx] ? ram_q : REC_RESET;
  assign st_j    = link_r[rd_idx_r];
  assign limit   = rec_q.last_seen + timeout_r;

  // Scan: read entry iss_r, evaluate the entry read last cycle.
  always_comb begin
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    ev_nxt       = ev_r;
    ev_idx_nxt   = ev_idx_r;
    best_nxt     = best_r;
    link_nxt     = link_r;
    written_nxt  = written_r;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_r;
    ram_wdata    = rec_q;
    ram_raddr    = iss_r[IW-1:0];
    rec_new      = rec_q;
    st_new       = ST_UNUSED;
    if (state_r == S_SCAN && rd_valid_r) begin
      case (item_r.opcode)
        OP_DISCOVER: begin
          if (st_j != ST_UNUSED && rec_q.addr == item_r.peer_addr &&
              rec_q.addr_kind == item_r.peer_addr_kind && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
          end
          if (st_j == ST_UNUSED && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (!free_r && st_j == ST_NOTCONN && rec_q.metric > best_r) begin
            ev_nxt     = 1'b1;
            ev_idx_nxt = rd_idx_r;
            best_nxt   = rec_q.metric;
          end
        end
        OP_UPLINK, OP_DOWNLINK, OP_CLOSE: begin
          if (st_j != ST_UNUSED && rec_q.addr == key_rev && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
          end
        end
        OP_TICK: begin
          if (st_j == ST_NOTCONN && limit < item_r.time_ms) begin
            link_nxt[rd_idx_r] = ST_UNUSED;
          end
        end
        OP_BEST: begin
          if (st_j == item_r.wanted_state &&
              (item_r.metric_kind == 4'd0 || rec_q.metric_kind == item_r.metric_kind) &&
              (!hit_r || rec_q.metric < best_r)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            best_nxt    = rec_q.metric;
          end
        end
        OP_HANDLE: begin
          if (st_j != ST_UNUSED && rec_q.handle == item_r.link_handle && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
          end
        end
        default: begin
          // purge: write back with metric and handle cleared
          ram_we           = 1'b1;
          ram_wdata.metric = 32'd0;
          ram_wdata.handle = HANDLE_NONE;
          written_nxt[rd_idx_r] = 1'b1;
        end
      endcase
    end
    if (state_r == S_DECIDE) begin
      ram_raddr = dec_slot;
    end
    if (state_r == S_WRITE) begin
      st_new = link_r[slot_r];
      case (item_r.opcode)
        OP_DISCOVER: begin
          rec_new.signal      = item_r.signal_dbm;
          rec_new.metric_kind = item_r.metric_kind;
          rec_new.metric      = item_r.metric_value;
          rec_new.last_seen   = item_r.time_ms;
          if (is_new_r) begin
            rec_new.addr      = item_r.peer_addr;
            rec_new.addr_kind = item_r.peer_addr_kind;
            st_new            = ST_NOTCONN;
          end
        end
        OP_UPLINK: begin
          rec_new.handle = item_r.link_handle;
          st_new         = ST_UPLINK;
        end
        OP_DOWNLINK: begin
          rec_new.handle = item_r.link_handle;
          st_new         = ST_DOWNLINK;
        end
        OP_CLOSE: begin
          rec_new.handle = HANDLE_NONE;
          st_new         = ST_NOTCONN;
        end
        default: begin
        end
      endcase
      if (item_r.opcode == OP_DISCOVER || item_r.opcode == OP_UPLINK ||
          item_r.opcode == OP_DOWNLINK || item_r.opcode == OP_CLOSE) begin
        ram_we              = 1'b1;
        ram_waddr           = slot_r;
        ram_wdata           = rec_new;
        written_nxt[slot_r] = 1'b1;
        link_nxt[slot_r]    = st_new;
      end
    end
  end

  // Pick the slot once the scan is done.
  always_comb begin
    dec_found = 1'b0;
    dec_new   = 1'b0;
    dec_slot  = hit_idx_r;
    case (item_r.opcode)
      OP_DISCOVER: begin
        if (reject) begin
          dec_found = 1'b0;
        end else if (hit_r) begin
          dec_found = 1'b1;
        end else if (item_r.can_connect && free_r) begin
          dec_found = 1'b1;
          dec_new   = 1'b1;
          dec_slot  = free_idx_r;
        end else if (item_r.can_connect && ev_r) begin
          dec_found = 1'b1;
          dec_new   = 1'b1;
          dec_slot  = ev_idx_r;
        end
      end
      OP_TICK, OP_PURGE: dec_found = 1'b0;
      default: dec_found = hit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      type_mask_r <= TYPE_MASK_RST;
      timeout_r   <= TIMEOUT_RST;
      written_r   <= '0;
      out_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        link_r[i] <= ST_UNUSED;
      end
    end else begin
      out_valid_r <= 1'b0;
      link_r      <= link_nxt;
      written_r   <= written_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TYPE_MASK: type_mask_r <= cfg_wdata[15:0];
          default:       timeout_r   <= cfg_wdata;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r     <= in_item;
            iss_r      <= '0;
            rd_valid_r <= 1'b0;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            ev_r       <= 1'b0;
            best_r     <= in_item.metric_value;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          hit_r      <= hit_nxt;
          hit_idx_r  <= hit_idx_nxt;
          free_r     <= free_nxt;
          free_idx_r <= free_idx_nxt;
          ev_r       <= ev_nxt;
          ev_idx_r   <= ev_idx_nxt;
          best_r     <= best_nxt;
          if (iss_r < CW'(TABLE_ENTRIES)) begin
            rd_valid_r <= 1'b1;
            rd_idx_r   <= iss_r[IW-1:0];
            iss_r      <= iss_r + 1'b1;
          end else begin
            rd_valid_r <= 1'b0;
            state_r    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          slot_r   <= dec_slot;
          is_new_r <= dec_new;
          if (dec_found) begin
            state_r <= S_WRITE;
          end else begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{status: (reject ? STS_BADTYPE :
                                      (item_r.opcode == OP_TICK ||
                                       item_r.opcode == OP_PURGE) ? STS_OK : STS_NONE),
                             slot_index: 6'd0, entry_addr: 48'd0,
                             entry_addr_kind: 2'd0, entry_signal: 8'sd0,
                             entry_metric_kind: 4'd0, entry_metric: 32'd0,
                             entry_handle: HANDLE_NONE, entry_state: ST_UNUSED};
            state_r <= S_IDLE;
          end
        end
        S_WRITE: begin
          out_valid_r <= 1'b1;
          out_item_r  <= '{status: STS_OK, slot_index: 6'(slot_r),
                           entry_addr: rec_new.addr, entry_addr_kind: rec_new.addr_kind,
                           entry_signal: rec_new.signal,
                           entry_metric_kind: rec_new.metric_kind,
                           entry_metric: rec_new.metric, entry_handle: rec_new.handle,
                           entry_state: st_new};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted but block not busy");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STS_NONE) |->
      (out_item.slot_index == 6'd0 && out_item.entry_handle == HANDLE_NONE))
    else $error("failed item reports an entry");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status != 2'd3)) else $error("illegal status");

endmodule

// ===== tb/tb_mesh_neighbor_table_unit.sv =====
`timescale 1ns / 1ps
// Testbench for mesh_neighbor_table_unit: directed and random table commands, with a
// cycle-free predictor of the neighbor table checking every result strobe.
// Depends on mnt_pkg and the RTL only.
module tb_mesh_neighbor_table_unit;
  import mnt_pkg::*;

  localparam int N = 8;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;

  mesh_neighbor_table_unit #(.TABLE_ENTRIES(N)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // predictor copy of the table
  logic [15:0] type_mask;
  logic [31:0] stale_ms;
  logic [1:0]  nb_state [N];
  logic [47:0] nb_addr [N];
  logic [1:0]  nb_kind [N];
  logic [7:0]  nb_sig [N];
  logic [3:0]  nb_mkind [N];
  logic [31:0] nb_metric [N];
  logic [3:0]  nb_handle [N];
  logic [31:0] nb_seen [N];

  in_item_t  cmd_queue[$];
  out_item_t expected_results[$];
  int        errors = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  bit        hold_off = 0;

  // known addresses, to aim connect/close/rediscovery at live peers
  logic [47:0] addr_pool [8];

  function automatic logic [47:0] swap_bytes(input logic [47:0] a);
    logic [47:0] r;
    for (int i = 0; i < 6; i++) r[8*(5-i) +: 8] = a[8*i +: 8];
    return r;
  endfunction

  function automatic out_item_t report_slot(input logic [1:0] sts, input int slot);
    out_item_t r;
    r = '0;
    r.status = sts;
    r.entry_handle = HANDLE_NONE;
    if (slot >= 0) begin
      r.slot_index = slot[5:0];
      r.entry_addr = nb_addr[slot];
      r.entry_addr_kind = nb_kind[slot];
      r.entry_signal = nb_sig[slot];
      r.entry_metric_kind = nb_mkind[slot];
      r.entry_metric = nb_metric[slot];
      r.entry_handle = nb_handle[slot];
      r.entry_state = nb_state[slot];
    end
    return r;
  endfunction

  function automatic void table_clear();
    type_mask = TYPE_MASK_RST;
    stale_ms = TIMEOUT_RST;
    for (int i = 0; i < N; i++) begin
      nb_state[i] = ST_UNUSED; nb_addr[i] = '0; nb_kind[i] = '0; nb_sig[i] = '0;
      nb_mkind[i] = '0; nb_metric[i] = '0; nb_handle[i] = HANDLE_NONE; nb_seen[i] = '0;
    end
  endfunction

  function automatic out_item_t table_apply(input in_item_t c);
    int slot;
    logic [31:0] highest;
    logic [47:0] key;
    slot = -1;
    case (c.opcode)
      OP_DISCOVER: begin
        if (!type_mask[c.metric_kind]) return report_slot(STS_BADTYPE, -1);
        for (int i = 0; i < N; i++)
          if (slot < 0 && nb_state[i] != ST_UNUSED && nb_addr[i] == c.peer_addr &&
              nb_kind[i] == c.peer_addr_kind) slot = i;
        if (slot < 0 && c.can_connect) begin
          highest = c.metric_value;
          for (int i = 0; i < N; i++) begin
            if (nb_state[i] == ST_UNUSED) begin
              slot = i;
              break;
            end
            if (nb_state[i] == ST_NOTCONN && nb_metric[i] > highest) begin
              highest = nb_metric[i];
              slot = i;
            end
          end
          if (slot >= 0) begin
            nb_addr[slot] = c.peer_addr;
            nb_kind[slot] = c.peer_addr_kind;
            nb_state[slot] = ST_NOTCONN;
          end
        end
        if (slot < 0) return report_slot(STS_NONE, -1);
        nb_sig[slot] = c.signal_dbm;
        nb_mkind[slot] = c.metric_kind;
        nb_metric[slot] = c.metric_value;
        nb_seen[slot] = c.time_ms;
        return report_slot(STS_OK, slot);
      end
      OP_UPLINK, OP_DOWNLINK, OP_CLOSE: begin
        key = swap_bytes(c.peer_addr);
        for (int i = 0; i < N; i++)
          if (slot < 0 && nb_state[i] != ST_UNUSED && nb_addr[i] == key) slot = i;
        if (slot < 0) return report_slot(STS_NONE, -1);
        if (c.opcode == OP_CLOSE) begin
          nb_state[slot] = ST_NOTCONN;
          nb_handle[slot] = HANDLE_NONE;
        end else begin
          nb_state[slot] = (c.opcode == OP_UPLINK) ? ST_UPLINK : ST_DOWNLINK;
          nb_handle[slot] = c.link_handle;
        end
        return report_slot(STS_OK, slot);
      end
      OP_TICK: begin
        for (int i = 0; i < N; i++)
          if (nb_state[i] == ST_NOTCONN && 32'(nb_seen[i] + stale_ms) < c.time_ms)
            nb_state[i] = ST_UNUSED;
        return report_slot(STS_OK, -1);
      end
      OP_BEST: begin
        for (int i = 0; i < N; i++)
          if (nb_state[i] == c.wanted_state &&
              (c.metric_kind == 0 || nb_mkind[i] == c.metric_kind) &&
              (slot < 0 || nb_metric[i] < nb_metric[slot])) slot = i;
        return report_slot(slot < 0 ? STS_NONE : STS_OK, slot);
      end
      OP_HANDLE: begin
        for (int i = 0; i < N; i++)
          if (slot < 0 && nb_state[i] != ST_UNUSED && nb_handle[i] == c.link_handle)
            slot = i;
        return report_slot(slot < 0 ? STS_NONE : STS_OK, slot);
      end
      default: begin
        for (int i = 0; i < N; i++) begin
          nb_metric[i] = '0;
          nb_handle[i] = HANDLE_NONE;
        end
        return report_slot(STS_OK, -1);
      end
    endcase
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t c;
    int pick;
    c.opcode = 3'($urandom_range(0, 7));
    c.peer_addr = {16'($urandom), 32'($urandom)};
    c.peer_addr_kind = 2'($urandom);
    c.signal_dbm = 8'($urandom);
    c.metric_kind = 4'($urandom);
    c.metric_value = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
    c.can_connect = ($urandom_range(0, 5) != 0);
    c.link_handle = 4'($urandom);
    c.wanted_state = 2'($urandom);
    c.time_ms = 32'($urandom_range(0, 30000));
    if ($urandom_range(0, 9) == 0) c.time_ms = 32'($urandom);
    // mostly reuse a small set of peers so updates, connects and evictions happen
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      c.peer_addr = addr_pool[pick % 8];
      c.peer_addr_kind = 2'(pick & 1);
      if (c.opcode inside {OP_UPLINK, OP_DOWNLINK, OP_CLOSE})
        c.peer_addr = swap_bytes(c.peer_addr);
    end
    if (c.opcode == OP_DISCOVER && $urandom_range(0, 2) != 0)
      c.peer_addr = addr_pool[$urandom_range(0, 7)];
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (!hold_off && cmd_queue.size() > 0) begin
        in_item <= cmd_queue[0];
        expected_results.push_back(table_apply(cmd_queue[0]));
        void'(cmd_queue.pop_front());
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: %p", out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, out_item.slot_index); errors++;
        end
        if (out_item.entry_addr !== e.entry_addr) begin
          $error("entry_addr exp %h got %h", e.entry_addr, out_item.entry_addr); errors++;
        end
        if (out_item.entry_addr_kind !== e.entry_addr_kind) begin
          $error("entry_addr_kind exp %0d got %0d", e.entry_addr_kind,
                 out_item.entry_addr_kind); errors++;
        end
        if (out_item.entry_signal !== e.entry_signal) begin
          $error("entry_signal exp %0d got %0d", e.entry_signal, out_item.entry_signal);
          errors++;
        end
        if (out_item.entry_metric_kind !== e.entry_metric_kind) begin
          $error("entry_metric_kind exp %0d got %0d", e.entry_metric_kind,
                 out_item.entry_metric_kind); errors++;
        end
        if (out_item.entry_metric !== e.entry_metric) begin
          $error("entry_metric exp %0d got %0d", e.entry_metric, out_item.entry_metric);
          errors++;
        end
        if (out_item.entry_handle !== e.entry_handle) begin
          $error("entry_handle exp %0d got %0d", e.entry_handle, out_item.entry_handle);
          errors++;
        end
        if (out_item.entry_state !== e.entry_state) begin
          $error("entry_state exp %0d got %0d", e.entry_state, out_item.entry_state);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || expected_results.size() > 0 || start || busy)
      @(posedge clk);
    repeat (N + 6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TYPE_MASK) type_mask = val[15:0];
    else stale_ms = val;
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [47:0] a, input logic [1:0] k,
                         input logic [3:0] mk, input logic [31:0] mv, input logic cc,
                         input logic [3:0] h, input logic [1:0] ws, input logic [31:0] t);
    in_item_t c;
    c.opcode = op; c.peer_addr = a; c.peer_addr_kind = k; c.signal_dbm = 8'($urandom);
    c.metric_kind = mk; c.metric_value = mv; c.can_connect = cc; c.link_handle = h;
    c.wanted_state = ws; c.time_ms = t;
    cmd_queue.push_back(c);
  endtask

  initial begin
    logic [31:0] timeouts [4];
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_idx = CFG_TYPE_MASK; cfg_wdata = '0;
    table_clear();
    for (int i = 0; i < 8; i++) addr_pool[i] = {16'($urandom), 32'($urandom)};
    addr_pool[0] = '1;
    addr_pool[1] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, type rejection, fill, eviction, connect, tick, purge
    hold_off = 1;
    add_cmd(OP_BEST, '0, 0, 0, 0, 0, 0, ST_UNUSED, 0);
    add_cmd(OP_HANDLE, '0, 0, 0, 0, 0, HANDLE_NONE, 0, 0);
    add_cmd(OP_DISCOVER, addr_pool[0], 3, 0, 5, 1, 0, 0, 100);
    for (int i = 0; i < N; i++)
      add_cmd(OP_DISCOVER, addr_pool[i], 2'(i), 4'(i + 1), 32'(10 * i + 5), 1, 0, 0, 32'(i));
    add_cmd(OP_DISCOVER, 48'h123456789ABC, 0, 15, 32'hFFFF_FFFF, 1, 0, 0, 0);
    add_cmd(OP_DISCOVER, 48'h123456789ABC, 0, 2, 0, 1, 0, 0, 32'hFFFF_FFFF);
    add_cmd(OP_DISCOVER, 48'h0000000000AA, 1, 2, 0, 0, 0, 0, 0);
    add_cmd(OP_DISCOVER, addr_pool[3], 3, 3, 7, 0, 0, 0, 50);
    add_cmd(OP_UPLINK, swap_bytes(addr_pool[2]), 0, 0, 0, 0, 4, 0, 0);
    add_cmd(OP_DOWNLINK, swap_bytes(addr_pool[3]), 0, 0, 0, 0, 15, 0, 0);
    add_cmd(OP_CLOSE, swap_bytes(addr_pool[3]), 0, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_UPLINK, 48'hDEAD_BEEF_0001, 0, 0, 0, 0, 1, 0, 0);
    add_cmd(OP_HANDLE, '0, 0, 0, 0, 0, 4, 0, 0);
    add_cmd(OP_BEST, '0, 0, 0, 0, 0, 0, ST_NOTCONN, 0);
    add_cmd(OP_BEST, '0, 0, 2, 0, 0, 0, ST_NOTCONN, 0);
    add_cmd(OP_BEST, '0, 0, 0, 0, 0, 0, ST_UPLINK, 0);
    add_cmd(OP_TICK, '0, 0, 0, 0, 0, 0, 0, 10007);
    add_cmd(OP_TICK, '0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    add_cmd(OP_PURGE, '0, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_HANDLE, '0, 0, 0, 0, 0, HANDLE_NONE, 0, 0);
    add_cmd(OP_BEST, '0, 0, 0, 0, 0, 0, ST_UNUSED, 0);
    hold_off = 0;
    wait_idle();

    // random phases across register settings, extremes included
    timeouts[0] = 32'd1; timeouts[1] = 32'hFFFF_FFFF;
    timeouts[2] = 32'd10000; timeouts[3] = 32'd3000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(CFG_TYPE_MASK, 32'hFFFF);
        1: write_reg(CFG_TYPE_MASK, 32'h0000);
        2: write_reg(CFG_TYPE_MASK, 32'(16'($urandom)));
        3: write_reg(CFG_TYPE_MASK, 32'hFFFE);
        default: write_reg(CFG_TYPE_MASK, 32'h5555);
      endcase
      write_reg(CFG_TIMEOUT, ph < 4 ? timeouts[ph] : 32'($urandom_range(1, 20000)));
      for (int j = 0; j < 150; j++) cmd_queue.push_back(rand_cmd());
      // pause once mid-phase until the table has answered everything
      if (ph == 2) begin
        while (cmd_queue.size() >= 75) @(posedge clk);
        hold_off = 1;
        while (expected_results.size() > 0 || busy || start) @(posedge clk);
        hold_off = 0;
      end
      wait_idle();
    end
    repeat (2 * N + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mnt_pkg.sv
rtl/mnt_ram.sv
rtl/mesh_neighbor_table_unit.sv
tb/tb_mesh_neighbor_table_unit.sv
